@@ rtl/string_to_signed_integer_top_defines.svh @@
// Assertion macros used by the parse core of the string to signed integer parser RTL.
`ifndef STRING_TO_SIGNED_INTEGER_TOP_DEFINES_SVH
`define STRING_TO_SIGNED_INTEGER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define S2I_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define S2I_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/s2i_pkg.sv @@
// Types, constants and codes of the string to signed integer parser.
package s2i_pkg;

    // Word and offset sizes of the parser.
    localparam int WORD_BITS       = 64;
    localparam int OFFSET_BITS     = 16;

    // Fixed widths of the stream fields.
    localparam int CH_BITS         = 8;
    localparam int BASE_BITS       = 6;
    localparam int DIGIT_BITS      = 6;
    localparam int OUT_VALUE_BITS  = 64;
    localparam int STATUS_BITS     = 2;
    localparam int OUT_OFFSET_BITS = 16;
    localparam int OUT_PAD_BITS    = 6;
    localparam int OUT_DATA_BITS   = OUT_VALUE_BITS + STATUS_BITS + OUT_OFFSET_BITS
                                     + OUT_PAD_BITS;

    // Product of the accumulator and the base plus one digit.
    localparam int PROD_BITS       = WORD_BITS + BASE_BITS + 1;

    // Signed limits of the word, as raw bit patterns.
    localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};

    // Base values.
    localparam logic [BASE_BITS-1:0] BASE_AUTO     = 6'd0;
    localparam logic [BASE_BITS-1:0] BASE_ONE      = 6'd1;
    localparam logic [BASE_BITS-1:0] BASE_MIN      = 6'd2;
    localparam logic [BASE_BITS-1:0] BASE_OCT      = 6'd8;
    localparam logic [BASE_BITS-1:0] BASE_DEC      = 6'd10;
    localparam logic [BASE_BITS-1:0] BASE_HEX      = 6'd16;
    localparam logic [BASE_BITS-1:0] BASE_MAX      = 6'd36;
    localparam logic [BASE_BITS-1:0] BASE_RESET    = BASE_DEC;

    // Digit value of a byte that is no digit at all; above every base.
    localparam logic [DIGIT_BITS-1:0] NOT_DIGIT    = 6'd63;

    // Characters.
    localparam logic [CH_BITS-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_BITS-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_BITS-1:0] CH_CR    = 8'h0D;
    localparam logic [CH_BITS-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_BITS-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_BITS-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_BITS-1:0] CH_NINE  = 8'h39;
    localparam logic [CH_BITS-1:0] CH_UA    = 8'h41;
    localparam logic [CH_BITS-1:0] CH_UZ    = 8'h5A;
    localparam logic [CH_BITS-1:0] CH_LA    = 8'h61;
    localparam logic [CH_BITS-1:0] CH_LZ    = 8'h7A;
    localparam logic [CH_BITS-1:0] CH_UX    = 8'h58;
    localparam logic [CH_BITS-1:0] CH_LX    = 8'h78;
    localparam logic [CH_BITS-1:0] LETTER_BIAS = 8'd10;

    // Result status codes.
    localparam logic [STATUS_BITS-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_RANGE  = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_NOCONV = 2'd2;

    // Parser phase, one-hot.
    typedef enum logic [5:0] {
        PH_IDLE   = 6'b000001,
        PH_SPACE  = 6'b000010,
        PH_SIGNED = 6'b000100,
        PH_ZERO   = 6'b001000,
        PH_ZEROX  = 6'b010000,
        PH_DIGITS = 6'b100000
    } t_phase;

    // Classification of one character.
    typedef struct packed {
        logic                  is_space;
        logic                  is_minus;
        logic                  is_plus;
        logic                  is_zero;
        logic                  is_x;
        logic [DIGIT_BITS-1:0] digit;
    } t_char_class;

endpackage

@@ rtl/s2i_char_class.sv @@
// Character classifier: white space, sign, prefix characters and digit value.
module s2i_char_class (
    input  logic [s2i_pkg::CH_BITS-1:0] i_ch,
    output s2i_pkg::t_char_class        o_class
);

    logic [s2i_pkg::CH_BITS-1:0] w_digit;

    // Digit value of 0-9, A-Z and a-z; every other byte is no digit.
    always_comb begin
        if (i_ch >= s2i_pkg::CH_ZERO && i_ch <= s2i_pkg::CH_NINE) begin
            w_digit = i_ch - s2i_pkg::CH_ZERO;
        end else if (i_ch >= s2i_pkg::CH_UA && i_ch <= s2i_pkg::CH_UZ) begin
            w_digit = i_ch - s2i_pkg::CH_UA + s2i_pkg::LETTER_BIAS;
        end else if (i_ch >= s2i_pkg::CH_LA && i_ch <= s2i_pkg::CH_LZ) begin
            w_digit = i_ch - s2i_pkg::CH_LA + s2i_pkg::LETTER_BIAS;
        end else begin
            w_digit = {2'b00, s2i_pkg::NOT_DIGIT};
        end
    end

    // Character flags.
    assign o_class.is_space = (i_ch == s2i_pkg::CH_SPACE) ||
                              (i_ch >= s2i_pkg::CH_TAB && i_ch <= s2i_pkg::CH_CR);
    assign o_class.is_minus = (i_ch == s2i_pkg::CH_MINUS);
    assign o_class.is_plus  = (i_ch == s2i_pkg::CH_PLUS);
    assign o_class.is_zero  = (i_ch == s2i_pkg::CH_ZERO);
    assign o_class.is_x     = (i_ch == s2i_pkg::CH_LX) || (i_ch == s2i_pkg::CH_UX);
    assign o_class.digit    = w_digit[s2i_pkg::DIGIT_BITS-1:0];

endmodule

@@ rtl/s2i_parse_core.sv @@
// Parser state, one-character step logic and the result register.
`include "string_to_signed_integer_top_defines.svh"

module s2i_parse_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    input  logic                                 i_start,
    input  s2i_pkg::t_char_class                 i_class,
    input  logic [s2i_pkg::BASE_BITS-1:0]        i_number_base,
    output logic                                 o_advance,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [s2i_pkg::OUT_VALUE_BITS-1:0]   o_value,
    output logic [s2i_pkg::STATUS_BITS-1:0]      o_status,
    output logic [s2i_pkg::OUT_OFFSET_BITS-1:0]  o_offset
);

    // Parser state.
    s2i_pkg::t_phase                      r_phase, n_phase;
    logic                                 r_neg, n_neg;
    logic [s2i_pkg::WORD_BITS-1:0]        r_acc, n_acc;
    logic                                 r_ovf, n_ovf;
    logic                                 r_any, n_any;
    logic [s2i_pkg::BASE_BITS-1:0]        r_base, n_base;
    logic [s2i_pkg::OFFSET_BITS-1:0]      r_pos, n_pos;
    logic [s2i_pkg::OFFSET_BITS-1:0]      r_pfx, n_pfx;

    // Result register.
    logic                                 r_out_valid;
    logic [s2i_pkg::OUT_VALUE_BITS-1:0]   r_out_value, n_out_value;
    logic [s2i_pkg::STATUS_BITS-1:0]      r_out_status, n_out_status;
    logic [s2i_pkg::OUT_OFFSET_BITS-1:0]  r_out_offset, n_out_offset;

    // State as seen by this character, after a start has cleared it.
    s2i_pkg::t_phase                      s_phase;
    logic                                 s_neg;
    logic [s2i_pkg::WORD_BITS-1:0]        s_acc;
    logic                                 s_ovf;
    logic                                 s_any;
    logic [s2i_pkg::BASE_BITS-1:0]        s_base;
    logic [s2i_pkg::OFFSET_BITS-1:0]      s_pos;
    logic [s2i_pkg::OFFSET_BITS-1:0]      s_pfx;

    logic                                 w_bad_base;
    logic                                 w_take;
    logic [s2i_pkg::BASE_BITS-1:0]        w_take_base;
    logic                                 w_digit_ok;
    logic [s2i_pkg::WORD_BITS-1:0]        w_limit;
    logic [s2i_pkg::PROD_BITS-1:0]        w_prod;
    logic                                 w_fin;
    logic                                 w_fin_any;
    logic [s2i_pkg::OFFSET_BITS-1:0]      w_fin_off;
    logic                                 w_inc;
    logic [s2i_pkg::WORD_BITS-1:0]        w_word;

    // The step runs whenever a character waits and the result register can take a beat.
    assign o_advance = i_in_valid && (!r_out_valid || i_out_ready);

    // A start byte clears the text state and latches the base.
    always_comb begin
        if (i_start) begin
            s_phase = s2i_pkg::PH_SPACE;
            s_neg   = 1'b0;
            s_acc   = '0;
            s_ovf   = 1'b0;
            s_any   = 1'b0;
            s_base  = i_number_base;
            s_pos   = '0;
            s_pfx   = '0;
        end else begin
            s_phase = r_phase;
            s_neg   = r_neg;
            s_acc   = r_acc;
            s_ovf   = r_ovf;
            s_any   = r_any;
            s_base  = r_base;
            s_pos   = r_pos;
            s_pfx   = r_pfx;
        end
    end

    assign w_bad_base = i_start && ((i_number_base == s2i_pkg::BASE_ONE) ||
                                    (i_number_base > s2i_pkg::BASE_MAX));

    // Base that a digit of this character is taken in, by phase.
    always_comb begin
        case (s_phase)
            s2i_pkg::PH_SPACE, s2i_pkg::PH_SIGNED: begin
                w_take_base = (s_base == s2i_pkg::BASE_AUTO) ? s2i_pkg::BASE_DEC : s_base;
            end
            s2i_pkg::PH_ZERO: begin
                w_take_base = (s_base == s2i_pkg::BASE_AUTO) ? s2i_pkg::BASE_OCT : s_base;
            end
            s2i_pkg::PH_ZEROX: begin
                w_take_base = s2i_pkg::BASE_HEX;
            end
            default: begin
                w_take_base = s_base;
            end
        endcase
    end

    // Multiply-add against the signed limit of the current sign.
    assign w_digit_ok = (i_class.digit < w_take_base) && (w_take_base >= s2i_pkg::BASE_MIN);
    assign w_limit    = s_neg ? s2i_pkg::WORD_MIN : s2i_pkg::WORD_MAX;
    assign w_prod     = s2i_pkg::PROD_BITS'(s_acc) * s2i_pkg::PROD_BITS'(w_take_base)
                        + s2i_pkg::PROD_BITS'(i_class.digit);

    // One character step.
    always_comb begin
        n_phase     = s_phase;
        n_neg       = s_neg;
        n_acc       = s_acc;
        n_ovf       = s_ovf;
        n_any       = s_any;
        n_base      = s_base;
        n_pfx       = s_pfx;
        w_take      = 1'b0;
        w_fin       = 1'b0;
        w_fin_any   = s_any;
        w_fin_off   = s_pos;
        w_inc       = 1'b0;

        if (w_bad_base) begin
            // An invalid base ends the text on its start byte with no conversion.
            w_fin     = 1'b1;
            w_fin_any = 1'b0;
            w_fin_off = '0;
            n_phase   = s2i_pkg::PH_IDLE;
        end else if (s_phase != s2i_pkg::PH_IDLE) begin
            w_inc = 1'b1;
            case (s_phase)
                s2i_pkg::PH_SPACE, s2i_pkg::PH_SIGNED: begin
                    if (s_phase == s2i_pkg::PH_SPACE && i_class.is_space) begin
                        n_phase = s2i_pkg::PH_SPACE;
                    end else if (s_phase == s2i_pkg::PH_SPACE && i_class.is_minus) begin
                        n_neg   = 1'b1;
                        n_phase = s2i_pkg::PH_SIGNED;
                    end else if (s_phase == s2i_pkg::PH_SPACE && i_class.is_plus) begin
                        n_phase = s2i_pkg::PH_SIGNED;
                    end else if (i_class.is_zero && (s_base == s2i_pkg::BASE_AUTO ||
                                                     s_base == s2i_pkg::BASE_HEX)) begin
                        n_phase = s2i_pkg::PH_ZERO;
                    end else begin
                        w_take = 1'b1;
                    end
                end
                s2i_pkg::PH_ZERO: begin
                    if (i_class.is_x) begin
                        n_pfx   = s_pos;
                        n_phase = s2i_pkg::PH_ZEROX;
                    end else begin
                        // The leading zero counts as a digit.
                        n_any       = 1'b1;
                        w_fin_any   = 1'b1;
                        w_take      = 1'b1;
                    end
                end
                s2i_pkg::PH_ZEROX: begin
                    if (i_class.digit < s2i_pkg::BASE_HEX) begin
                        w_take = 1'b1;
                    end else begin
                        // Prefix without a hex digit: only the zero converts.
                        n_any     = 1'b1;
                        w_fin     = 1'b1;
                        w_fin_any = 1'b1;
                        w_fin_off = s_pfx;
                        n_phase   = s2i_pkg::PH_IDLE;
                    end
                end
                default: begin
                    w_take = 1'b1;
                end
            endcase

            // Shared digit step: accumulate or end the number.
            if (w_take) begin
                n_base  = w_take_base;
                n_phase = s2i_pkg::PH_DIGITS;
                if (!w_digit_ok) begin
                    w_fin   = 1'b1;
                    n_phase = s2i_pkg::PH_IDLE;
                end else begin
                    n_any = 1'b1;
                    if (s_ovf || (w_prod > s2i_pkg::PROD_BITS'(w_limit))) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_acc = w_prod[s2i_pkg::WORD_BITS-1:0];
                    end
                end
            end
        end
    end

    // Offset counter saturates at its maximum.
    assign n_pos = (w_inc && s_pos != s2i_pkg::POS_MAX) ? s_pos + 1'b1 : s_pos;

    // Result value and status of a finished number.
    always_comb begin
        if (!w_fin_any) begin
            w_word       = '0;
            n_out_status = s2i_pkg::ST_NOCONV;
            n_out_offset = '0;
        end else if (s_ovf) begin
            w_word       = s_neg ? s2i_pkg::WORD_MIN : s2i_pkg::WORD_MAX;
            n_out_status = s2i_pkg::ST_RANGE;
            n_out_offset = s2i_pkg::OUT_OFFSET_BITS'(w_fin_off);
        end else begin
            w_word       = s_neg ? (~s_acc + 1'b1) : s_acc;
            n_out_status = s2i_pkg::ST_OK;
            n_out_offset = s2i_pkg::OUT_OFFSET_BITS'(w_fin_off);
        end
        n_out_value = s2i_pkg::OUT_VALUE_BITS'($signed(w_word));
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= s2i_pkg::PH_IDLE;
            r_neg   <= 1'b0;
            r_acc   <= '0;
            r_ovf   <= 1'b0;
            r_any   <= 1'b0;
            r_base  <= '0;
            r_pos   <= '0;
            r_pfx   <= '0;
        end else if (o_advance) begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_acc   <= n_acc;
            r_ovf   <= n_ovf;
            r_any   <= n_any;
            r_base  <= n_base;
            r_pos   <= n_pos;
            r_pfx   <= n_pfx;
        end
    end

    // Result register: loads on a finished number, empties when the beat is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_advance && w_fin) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && w_fin) begin
            r_out_value  <= n_out_value;
            r_out_status <= n_out_status;
            r_out_offset <= n_out_offset;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_out_value;
    assign o_status    = r_out_status;
    assign o_offset    = r_out_offset;

    // A finished number shows up as a result beat and leaves the parser idle.
    `S2I_ASSERT_NEXT(a_fin_loads, i_clk, i_rst_n, o_advance && w_fin, r_out_valid && (r_phase == s2i_pkg::PH_IDLE), "finished number did not load a result")
    // No conversion always reports a zero value at offset zero.
    `S2I_ASSERT_NOW(a_noconv_zero, i_clk, i_rst_n, r_out_valid && (r_out_status == s2i_pkg::ST_NOCONV), (r_out_value == '0) && (r_out_offset == '0), "no-conversion result is not zero")
    // An out-of-range result is one of the two signed limits.
    `S2I_ASSERT_NOW(a_range_sat, i_clk, i_rst_n, r_out_valid && (r_out_status == s2i_pkg::ST_RANGE), (r_out_value[s2i_pkg::WORD_BITS-1:0] == s2i_pkg::WORD_MAX) || (r_out_value[s2i_pkg::WORD_BITS-1:0] == s2i_pkg::WORD_MIN), "out-of-range result not saturated")
    // The parser only counts digits in the digit phase with a usable base.
    `S2I_ASSERT_NOW(a_digit_base, i_clk, i_rst_n, r_phase == s2i_pkg::PH_DIGITS, (r_base >= s2i_pkg::BASE_MIN) && (r_base <= s2i_pkg::BASE_MAX), "digit phase without a valid base")

endmodule

@@ rtl/string_to_signed_integer_top.sv @@
// An accepted input beat passes the input register and the result register in turn.
// Throughput: one character per cycle, set by the combinational multiply-add step;
// the input side stalls only while a result beat waits and the master is not ready.
// Reset (i_rst_n low, synchronous): the parser returns to idle, both stages empty,
// and the base register goes back to 10.
module string_to_signed_integer_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Configuration: number base.
    input  logic                                 i_cfg_we,
    input  logic [s2i_pkg::BASE_BITS-1:0]        i_cfg_wdata,
    // Slave side.
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  logic [s2i_pkg::CH_BITS-1:0]          i_s_axis_tdata,  // [7:0] ch
    input  logic                                 i_s_axis_tuser,  // [0] start_req
    // Master side.
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // [63:0] value, [65:64] status, [81:66] end_offset, [87:82] zero
    output logic [s2i_pkg::OUT_DATA_BITS-1:0]    o_m_axis_tdata
);

    logic                                 r_in_valid;
    logic                                 r_in_start;
    logic [s2i_pkg::CH_BITS-1:0]          r_in_ch;
    logic [s2i_pkg::BASE_BITS-1:0]        r_number_base;

    s2i_pkg::t_char_class                 w_class;
    logic                                 w_advance;
    logic [s2i_pkg::OUT_VALUE_BITS-1:0]   w_value;
    logic [s2i_pkg::STATUS_BITS-1:0]      w_status;
    logic [s2i_pkg::OUT_OFFSET_BITS-1:0]  w_offset;

    // Base register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_base <= s2i_pkg::BASE_RESET;
        end else if (i_cfg_we) begin
            r_number_base <= i_cfg_wdata;
        end
    end

    // Input register takes a beat whenever it is empty or being consumed.
    assign o_s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_start <= i_s_axis_tuser;
            r_in_ch    <= i_s_axis_tdata;
        end
    end

    // Character classification.
    s2i_char_class u_char_class (
        .i_ch    (r_in_ch),
        .o_class (w_class)
    );

    // Parser step and result register.
    s2i_parse_core u_parse_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (r_in_valid),
        .i_start       (r_in_start),
        .i_class       (w_class),
        .i_number_base (r_number_base),
        .o_advance     (w_advance),
        .o_out_valid   (o_m_axis_tvalid),
        .i_out_ready   (i_m_axis_tready),
        .o_value       (w_value),
        .o_status      (w_status),
        .o_offset      (w_offset)
    );

    // Result beat packing.
    assign o_m_axis_tdata = {{s2i_pkg::OUT_PAD_BITS{1'b0}}, w_offset, w_status, w_value};

endmodule
